// ----- sv/pdt_pkg.sv -----
// Shared constants and types for the prescaled down timer.
package pdt_pkg;

  localparam int COUNT_BITS = 12;
  localparam int DATA_W     = 16;
  localparam int PRE_W      = 4;

  typedef logic [2:0] cmd_t;

  localparam cmd_t CMD_TICK      = 3'd0;
  localparam cmd_t CMD_RD_COUNT  = 3'd1;
  localparam cmd_t CMD_RD_RELOAD = 3'd2;
  localparam cmd_t CMD_RD_STATUS = 3'd3;
  localparam cmd_t CMD_WR_RELOAD = 3'd4;
  localparam cmd_t CMD_WR_STATUS = 3'd5;

  localparam int ST_ENABLE_BIT = 0;
  localparam int ST_OVF_BIT    = 3;
  localparam int ST_EXT_BIT    = 5;
  localparam int ST_IRQEN_BIT  = 6;
  localparam int ST_ZERO_BIT   = 7;

  localparam logic [DATA_W-1:0] ST_KEEP      = 16'o250;
  localparam logic [DATA_W-1:0] ST_RD_CLEAR  = 16'o050;

endpackage

// ----- sv/prescaled_down_timer_with_status.sv -----
// Top level: prescaled 12-bit down timer with status and reload registers.
//
//  channel | dir | tdata            | tuser
//  --------+-----+------------------+-------------
//  in_     | in  | [15:0] write_data| [2:0] cmd
//  out_    | out | [15:0] read_data | [0] irq_pulse
//
// One beat per cycle sustained while the output is not stalled.
// An input register feeds the command/state update; the result lands in an
// output register. All state updates when the held beat moves to the output.
// A stalled output holds the input register, and in_tready drops once it is full.
// rst_n is synchronous; it clears the counter, reload, status and prescaler.
module prescaled_down_timer_with_status (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pdt_pkg::DATA_W-1:0]       in_tdata,   // [15:0] write_data
  input  pdt_pkg::cmd_t                    in_tuser,   // [2:0] cmd
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pdt_pkg::DATA_W-1:0]       out_tdata,  // [15:0] read_data
  output logic                             out_tuser   // [0] irq_pulse
);
  import pdt_pkg::*;

  logic                  in_valid_r;
  cmd_t                  cmd_r;
  logic [DATA_W-1:0]     wdata_r;

  logic                  out_valid_r;
  logic [DATA_W-1:0]     rdata_r;
  logic                  irq_r;

  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [COUNT_BITS-1:0] reload_r, reload_nxt;
  logic [DATA_W-1:0]     status_r, status_nxt;
  logic [PRE_W-1:0]      pre_r, pre_nxt;
  logic [DATA_W-1:0]     rdata_nxt;
  logic                  irq_nxt;

  logic                  adv;
  logic [PRE_W-1:0]      pre_inc;
  logic [PRE_W-1:0]      period;
  logic [COUNT_BITS-1:0] count_dec;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || adv;

  assign pre_inc   = pre_r + PRE_W'(1);
  assign period    = PRE_W'(1) << status_r[2:1];
  assign count_dec = count_r - COUNT_BITS'(1);

  always_comb begin
    count_nxt  = count_r;
    reload_nxt = reload_r;
    status_nxt = status_r;
    pre_nxt    = pre_r;
    rdata_nxt  = '0;
    irq_nxt    = 1'b0;
    case (cmd_r)
      CMD_TICK: begin
        if (status_r[ST_ENABLE_BIT]) begin
          pre_nxt = pre_inc;
          if (pre_inc >= period) begin
            pre_nxt   = '0;
            count_nxt = count_dec;
            if (count_dec == '0) begin
              if (status_r[ST_ZERO_BIT]) status_nxt[ST_OVF_BIT] = 1'b1;
              status_nxt[ST_ZERO_BIT] = 1'b1;
              count_nxt = reload_r;
              irq_nxt   = status_r[ST_IRQEN_BIT];
            end
          end
        end
      end
      CMD_RD_COUNT: begin
        rdata_nxt = DATA_W'(count_r);
        status_nxt[ST_ZERO_BIT] = 1'b0;
      end
      CMD_RD_RELOAD: rdata_nxt = DATA_W'(reload_r);
      CMD_RD_STATUS: begin
        rdata_nxt  = status_r;
        status_nxt = status_r & ~ST_RD_CLEAR;
      end
      CMD_WR_RELOAD: begin
        reload_nxt = wdata_r[COUNT_BITS-1:0];
        if (!status_r[ST_ENABLE_BIT]) count_nxt = wdata_r[COUNT_BITS-1:0];
      end
      CMD_WR_STATUS: begin
        if (wdata_r[ST_ENABLE_BIT] && !status_r[ST_ENABLE_BIT]) count_nxt = reload_r;
        status_nxt = (status_r & ST_KEEP) | (wdata_r & ~ST_KEEP);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      reload_r    <= '0;
      status_r    <= '0;
      pre_r       <= '0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (adv) out_valid_r <= in_valid_r;
      if (adv && in_valid_r) begin
        count_r  <= count_nxt;
        reload_r <= reload_nxt;
        status_r <= status_nxt;
        pre_r    <= pre_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r   <= in_tuser;
      wdata_r <= in_tdata;
    end
    if (adv && in_valid_r) begin
      rdata_r <= rdata_nxt;
      irq_r   <= irq_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = rdata_r;
  assign out_tuser  = irq_r;

  a_rd_count_clears_zero: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_valid_r && cmd_r == CMD_RD_COUNT |=> !status_r[ST_ZERO_BIT])
    else $error("zero flag not cleared by count read");

  a_irq_has_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && irq_r |-> status_r[ST_ZERO_BIT] && status_r[ST_IRQEN_BIT])
    else $error("irq without zero flag and irq enable");

  a_wr_status_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_valid_r && cmd_r == CMD_WR_STATUS
    |=> (status_r & ST_KEEP) == ($past(status_r) & ST_KEEP))
    else $error("status write altered kept bits");

  a_disabled_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_valid_r && cmd_r == CMD_TICK && !status_r[ST_ENABLE_BIT]
    |=> $stable(count_r) && $stable(pre_r) && !irq_r)
    else $error("disabled tick changed timer");

endmodule

// ----- sim/prescaled_down_timer_with_status_test.sv -----
// Self-checking testbench for the prescaled down timer: directed, then random bus beats against a timer predictor.
module prescaled_down_timer_with_status_test;
  import pdt_pkg::*;

  localparam cmd_t CMD_SPARE_6 = 3'd6;
  localparam cmd_t CMD_SPARE_7 = 3'd7;
  localparam int RANDOM_OPS = 1025;
  localparam int CALM_TAIL = 150;
  localparam int LONG_HOLD = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    cmd_t              cmd;
    logic [DATA_W-1:0] write_data;
  } bus_op_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq_pulse;
  } timer_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata = '0;
  cmd_t                  in_tuser = CMD_TICK;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [DATA_W-1:0]     out_tdata;
  logic                  out_tuser;

  bus_op_t               op_queue[$];
  timer_result_t         pending_results[$];

  logic [COUNT_BITS-1:0] tmr_count = '0;
  logic [COUNT_BITS-1:0] tmr_reload = '0;
  logic [DATA_W-1:0]     tmr_status = '0;
  logic [PRE_W-1:0]      tmr_prescale = '0;

  int total_ops = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_fail = 0;
  int n_irq = 0;
  int n_reads = 0;
  int cycle_count = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;

  prescaled_down_timer_with_status u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [15:0] write_data
    .in_tuser   (in_tuser),   // [2:0] cmd
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [15:0] read_data
    .out_tuser  (out_tuser)   // [0] irq_pulse
  );

  always #2 clk = ~clk;

  function automatic timer_result_t timer_apply(cmd_t cmd, logic [DATA_W-1:0] wdata);
    timer_result_t r;
    int unsigned period;
    r = '0;
    case (cmd)
      CMD_TICK: begin
        if (tmr_status[ST_ENABLE_BIT]) begin
          tmr_prescale = tmr_prescale + 1'b1;
          period = 1 << tmr_status[2:1];
          if (tmr_prescale >= period) begin
            tmr_prescale = '0;
            tmr_count = tmr_count - 1'b1;
            if (tmr_count == '0) begin
              if (tmr_status[ST_ZERO_BIT]) tmr_status[ST_OVF_BIT] = 1'b1;
              tmr_status[ST_ZERO_BIT] = 1'b1;
              tmr_count = tmr_reload;
              r.irq_pulse = tmr_status[ST_IRQEN_BIT];
            end
          end
        end
      end
      CMD_RD_COUNT: begin
        r.read_data[COUNT_BITS-1:0] = tmr_count;
        tmr_status[ST_ZERO_BIT] = 1'b0;
      end
      CMD_RD_RELOAD: begin
        r.read_data[COUNT_BITS-1:0] = tmr_reload;
      end
      CMD_RD_STATUS: begin
        r.read_data = tmr_status;
        tmr_status = tmr_status & ~ST_RD_CLEAR;
      end
      CMD_WR_RELOAD: begin
        tmr_reload = wdata[COUNT_BITS-1:0];
        if (!tmr_status[ST_ENABLE_BIT]) tmr_count = tmr_reload;
      end
      CMD_WR_STATUS: begin
        if (wdata[ST_ENABLE_BIT] && !tmr_status[ST_ENABLE_BIT]) tmr_count = tmr_reload;
        tmr_status = (tmr_status & ST_KEEP) | (wdata & ~ST_KEEP);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void queue_op(cmd_t cmd, logic [DATA_W-1:0] wdata);
    bus_op_t op;
    op.cmd = cmd;
    op.write_data = wdata;
    op_queue.push_back(op);
  endfunction

  function automatic bus_op_t random_op();
    bus_op_t op;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    op.write_data = DATA_W'($urandom());
    if (pick < 52) begin
      op.cmd = CMD_TICK;
    end else if (pick < 60) begin
      op.cmd = CMD_RD_COUNT;
    end else if (pick < 65) begin
      op.cmd = CMD_RD_RELOAD;
    end else if (pick < 73) begin
      op.cmd = CMD_RD_STATUS;
    end else if (pick < 81) begin
      op.cmd = CMD_WR_RELOAD;
      if ($urandom_range(0, 3) != 0) op.write_data = DATA_W'($urandom_range(0, 12));
    end else if (pick < 93) begin
      op.cmd = CMD_WR_STATUS;
      if ($urandom_range(0, 3) != 0) op.write_data[ST_ENABLE_BIT] = 1'b1;
    end else begin
      op.cmd = ($urandom_range(0, 1) == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
    end
    return op;
  endfunction

  // sender: one beat offered at a time, random idle bursts except near the end
  always @(posedge clk) begin : drive
    timer_result_t res;
    bus_op_t op;
    logic next_valid;
    if (!rst_n) begin
      tmr_count = '0;
      tmr_reload = '0;
      tmr_status = '0;
      tmr_prescale = '0;
      in_tvalid <= 1'b0;
    end else begin
      next_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        res = timer_apply(in_tuser, in_tdata);
        pending_results.push_back(res);
        n_sent++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_idle == 0 && op_queue.size() > CALM_TAIL && (op_queue.size() / 64) % 2 == 0
            && $urandom_range(0, 5) == 0)
          send_idle = $urandom_range(1, 14);
        if (send_idle > 0) begin
          send_idle--;
        end else if (op_queue.size() > 0) begin
          op = op_queue.pop_front();
          in_tdata <= op.write_data;
          in_tuser <= op.cmd;
          next_valid = 1'b1;
        end
      end
      in_tvalid <= next_valid;
    end
  end

  // receiver: checks each out beat, stalls in bursts and once for a long stretch
  always @(posedge clk) begin : watch
    timer_result_t exp_res;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("out beat with nothing expected: read_data %h irq_pulse %b",
                 out_tdata, out_tuser);
          n_fail++;
        end else begin
          exp_res = pending_results.pop_front();
          n_checked++;
          if (exp_res.irq_pulse) n_irq++;
          if (exp_res.read_data != '0) n_reads++;
          if (out_tdata !== exp_res.read_data) begin
            $error("read_data: expected %h, got %h", exp_res.read_data, out_tdata);
            n_fail++;
          end
          if (out_tuser !== exp_res.irq_pulse) begin
            $error("irq_pulse: expected %b, got %b", exp_res.irq_pulse, out_tuser);
            n_fail++;
          end
        end
      end
      if (!long_hold_done && n_checked >= 400) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (recv_stall == 0 && n_checked + CALM_TAIL < total_ops && (n_checked / 80) % 3 != 0
            && $urandom_range(0, 5) == 0)
          recv_stall = $urandom_range(1, 14);
        if (recv_stall > 0) begin
          recv_stall--;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    queue_op(CMD_RD_STATUS, 16'h0000);
    queue_op(CMD_WR_RELOAD, 16'hFFFF);
    queue_op(CMD_RD_COUNT, 16'h0000);
    queue_op(CMD_RD_RELOAD, 16'h0000);
    queue_op(CMD_WR_RELOAD, 16'h0002);
    queue_op(CMD_TICK, 16'hFFFF);
    queue_op(CMD_WR_STATUS, 16'hFFC9);
    queue_op(CMD_TICK, 16'h0000);
    queue_op(CMD_TICK, 16'h0000);
    queue_op(CMD_TICK, 16'h0000);
    queue_op(CMD_TICK, 16'h0000);
    queue_op(CMD_RD_STATUS, 16'h0000);
    queue_op(CMD_RD_STATUS, 16'h0000);
    queue_op(CMD_RD_COUNT, 16'h0000);
    queue_op(CMD_WR_STATUS, 16'h0047);
    queue_op(CMD_TICK, 16'h0000);
    queue_op(CMD_TICK, 16'h0000);
    queue_op(CMD_TICK, 16'h0000);
    // slower prescale to faster one while the prescaler is already past the new period
    queue_op(CMD_WR_STATUS, 16'h0043);
    queue_op(CMD_TICK, 16'h0000);
    queue_op(CMD_WR_RELOAD, 16'h0005);
    queue_op(CMD_WR_STATUS, 16'h0000);
    queue_op(CMD_SPARE_6, 16'hFFFF);
    queue_op(CMD_SPARE_7, 16'h0000);
    queue_op(CMD_WR_STATUS, 16'h0001);
    repeat (RANDOM_OPS) op_queue.push_back(random_op());
    total_ops = op_queue.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (n_sent != total_ops) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d bus beats with %0d nonzero reads and %0d timer interrupts,",
             n_checked, n_reads, n_irq);
    $display("under random stalls on both sides and one long output hold-off");
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
